// File: sv/sdsbr_pkg.sv
`timescale 1ns / 1ps
// Package for the SHiP/DRRIP replacement engine: controller states and
// controller/datapath command and status structs. No dependencies.
package sdsbr_pkg;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned OUT_W   = 4;
    localparam int unsigned CNT_W   = 5;
    localparam logic [1:0]  RRPV_INIT   = 2'd2;
    localparam logic [1:0]  RRPV_MAX    = 2'd3;
    localparam logic [1:0]  REUSE_INIT  = 2'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_INIT = 16'd128;
    localparam logic [0:0]  KIND_VICTIM = 1'b0;
    localparam logic [0:0]  KIND_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic exec;
        logic out_valid;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_victim;
    } ctrl_sts_t;

endpackage

// File: sv/sdsbr_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sdsbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/sdsbr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: clear sweep, read, execute, result hold.
// Depends on sdsbr_pkg.
module sdsbr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    input  sdsbr_pkg::ctrl_sts_t  sts,
    output sdsbr_pkg::ctrl_cmd_t  cmd
);
    import sdsbr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = sts.is_victim ? ST_OUT : ST_IDLE;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            ST_READ:  cmd.read = 1'b1;
            ST_EXEC:  cmd.exec = 1'b1;
            ST_OUT:   cmd.out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule

// File: sv/sdsbr_dp.sv
`timescale 1ns / 1ps
// Datapath: RRPV row, per-set stride and last-address memories, SHiP
// counters, dueling selector. Depends on sdsbr_pkg and sdsbr_ram.
module sdsbr_dp #(
    parameter int unsigned SETS         = 2048,
    parameter int unsigned WAYS         = 16,
    parameter int unsigned SIG_BITS     = 5,
    parameter int unsigned PSEL_WIDTH   = 10,
    parameter int unsigned LEADER_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdsbr_pkg::ctrl_cmd_t          cmd,
    output sdsbr_pkg::ctrl_sts_t          sts,
    input  logic [sdsbr_pkg::LIMIT_W-1:0] limit,
    input  logic                          kind,
    input  logic [10:0]                   set_index,
    input  logic [3:0]                    way,
    input  logic [15:0]                   valid_mask,
    input  logic [sdsbr_pkg::ADDR_W-1:0]  address,
    input  logic [sdsbr_pkg::ADDR_W-1:0]  pc,
    input  logic                          hit,
    output logic [sdsbr_pkg::OUT_W-1:0]   victim_way
);
    import sdsbr_pkg::*;

    localparam int unsigned SET_W  = $clog2(SETS);
    localparam int unsigned WAY_W  = $clog2(WAYS);
    localparam int unsigned ROW_W  = 2 * WAYS;
    localparam int unsigned SIGS   = 1 << SIG_BITS;
    localparam int unsigned STRIDE_RAW = SETS / LEADER_COUNT;
    localparam int unsigned STRIDE = (STRIDE_RAW == 0) ? 1 : STRIDE_RAW;
    localparam int unsigned STR_W  = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam int unsigned IDX_W  = SET_W + 1;
    localparam logic [PSEL_WIDTH-1:0] PSEL_TOP = {PSEL_WIDTH{1'b1}};
    localparam logic [PSEL_WIDTH-1:0] PSEL_MID = PSEL_TOP >> 1;
    localparam int unsigned MASK_W = (WAYS > 16) ? WAYS : 16;
    localparam int unsigned SIDX_W = (SET_W > 11) ? SET_W : 11;

    logic             kind_reg;
    logic [SET_W-1:0] set_reg;
    logic [3:0]       way_reg;
    logic [15:0]      mask_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIG_BITS-1:0] sig_reg;
    logic             hit_reg;
    logic [SET_W:0]   clr_reg;
    logic [1:0]       reuse_reg [SIGS];
    logic [PSEL_WIDTH-1:0] psel_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OUT_W-1:0] victim_reg;

    logic [ROW_W-1:0] row_rd;
    logic [1:0]       lvl_rd;
    logic [ADDR_W-1:0] last_rd;
    logic [ROW_W-1:0] row_wr;
    logic [1:0]       lvl_wr;
    logic [1:0]       lvl_new;
    logic [ADDR_W-1:0] last_wr;
    logic             we;
    logic [SET_W-1:0] waddr;
    logic [SET_W-1:0] raddr;
    logic [SIG_BITS-1:0] sig_in;
    logic [SIDX_W-1:0] set_ext;
    logic [1:0]       top;
    logic [1:0]       add;
    logic [ROW_W-1:0] aged;
    logic [OUT_W-1:0] pick;
    logic             found;
    logic [MASK_W-1:0] mask_ext;
    logic [ADDR_W-1:0] delta;
    logic             stride_hit;
    logic             streaming;
    logic [CNT_W-1:0] cnt_new;
    logic [IDX_W-1:0] lidx;
    logic             leader;
    logic             brrip;
    logic [1:0]       reuse_cur;
    logic [1:0]       reuse_new;
    logic [1:0]       ins;

    assign set_ext = SIDX_W'(set_index);
    assign sig_in  = SIG_BITS'(pc ^ (pc >> SIG_BITS) ^ (pc >> (2 * SIG_BITS)));
    assign raddr   = SET_W'(set_ext % SETS);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            set_reg  <= raddr;
            way_reg  <= way;
            mask_reg <= valid_mask;
            addr_reg <= address;
            sig_reg  <= sig_in;
            hit_reg  <= hit;
        end
        if (cmd.exec)
        begin
            victim_reg <= pick;
        end
    end

    sdsbr_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rrpv (
        .clk(clk), .we(we), .waddr(waddr), .wdata(row_wr),
        .raddr(set_reg), .rdata(row_rd)
    );
    sdsbr_ram #(.WIDTH(2), .DEPTH(SETS)) u_lvl (
        .clk(clk), .we(we), .waddr(waddr), .wdata(lvl_wr),
        .raddr(set_reg), .rdata(lvl_rd)
    );
    sdsbr_ram #(.WIDTH(ADDR_W), .DEPTH(SETS)) u_last (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata(last_wr),
        .raddr(set_reg), .rdata(last_rd)
    );

    // victim selection
    assign mask_ext = MASK_W'(mask_reg);
    always_comb
    begin
        top = 2'd0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_rd[2*w +: 2] > top) top = row_rd[2*w +: 2];
        end
        add = RRPV_MAX - top;
        for (int w = 0; w < WAYS; w++)
        begin
            aged[2*w +: 2] = row_rd[2*w +: 2] + add;
        end
        pick  = '0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && !mask_ext[w])
            begin
                pick  = OUT_W'(w);
                found = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && aged[2*w +: 2] == RRPV_MAX)
            begin
                pick  = OUT_W'(w);
                found = 1'b1;
            end
        end
    end

    // update path
    assign delta = (last_rd == '0) ? '0 :
                   (addr_reg >= last_rd) ? addr_reg - last_rd : last_rd - addr_reg;
    assign stride_hit = (delta != '0) && (delta <= ADDR_W'(limit));
    always_comb
    begin
        lvl_new = lvl_rd;
        if (stride_hit)
        begin
            if (lvl_rd != 2'd3) lvl_new = lvl_rd + 2'd1;
        end
        else if (lvl_rd != 2'd0)
        begin
            lvl_new = lvl_rd - 2'd1;
        end
    end
    assign streaming = lvl_new[1];
    assign cnt_new   = cnt_reg + CNT_W'(1);
    assign reuse_cur = reuse_reg[sig_reg];
    always_comb
    begin
        reuse_new = reuse_cur;
        if (hit_reg)
        begin
            if (reuse_cur != 2'd3) reuse_new = reuse_cur + 2'd1;
        end
        else if (reuse_cur != 2'd0)
        begin
            reuse_new = reuse_cur - 2'd1;
        end
    end
    assign lidx   = IDX_W'(set_reg / STRIDE);
    assign leader = (STR_W'(set_reg % STRIDE) == '0) && (lidx < IDX_W'(LEADER_COUNT));
    assign brrip  = leader ? (lidx >= IDX_W'(LEADER_COUNT / 2)) : (psel_reg >= PSEL_MID);
    always_comb
    begin
        if (hit_reg) ins = 2'd0;
        else if (streaming || reuse_new == 2'd0) ins = RRPV_MAX;
        else if (brrip && cnt_new == '0) ins = 2'd0;
        else ins = RRPV_INIT;
    end

    always_comb
    begin
        row_wr  = row_rd;
        lvl_wr  = lvl_new;
        last_wr = addr_reg;
        we      = 1'b0;
        waddr   = set_reg;
        if (cmd.clear_step)
        begin
            we      = !clr_reg[SET_W];
            waddr   = clr_reg[SET_W-1:0];
            row_wr  = {WAYS{RRPV_INIT}};
            lvl_wr  = 2'd0;
            last_wr = '0;
        end
        else if (cmd.exec)
        begin
            we = 1'b1;
            if (kind_reg == KIND_VICTIM)
            begin
                row_wr  = (mask_ext[WAYS-1:0] == {WAYS{1'b1}}) ? aged : row_rd;
                lvl_wr  = lvl_rd;
                last_wr = last_rd;
            end
            else if (32'(way_reg) < WAYS)
            begin
                row_wr[2*WAY_W'(way_reg) +: 2] = ins;
            end
        end
    end

    // last_rd written back unchanged on a victim request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            psel_reg <= PSEL_MID;
            cnt_reg  <= '0;
            for (int i = 0; i < SIGS; i++) reuse_reg[i] <= REUSE_INIT;
        end
        else
        begin
            if (cmd.clear_step && !clr_reg[SET_W]) clr_reg <= clr_reg + (SET_W+1)'(1);
            if (cmd.exec && kind_reg == KIND_UPDATE)
            begin
                cnt_reg <= cnt_new;
                reuse_reg[sig_reg] <= reuse_new;
                if (leader && !hit_reg)
                begin
                    if (!brrip)
                    begin
                        if (psel_reg != PSEL_TOP) psel_reg <= psel_reg + PSEL_WIDTH'(1);
                    end
                    else if (psel_reg != '0)
                    begin
                        psel_reg <= psel_reg - PSEL_WIDTH'(1);
                    end
                end
            end
        end
    end

    assign sts.clear_done = clr_reg[SET_W];
    assign sts.is_victim  = (kind_reg == KIND_VICTIM);
    assign victim_way     = victim_reg;
endmodule

// File: sv/ship_drrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps
// SHiP + streaming-bypass DRRIP replacement engine, top level.
// Depends on sdsbr_pkg, sdsbr_ctrl, sdsbr_dp, sdsbr_ram.
//
// Input channel (in_valid/in_ready) carries one transaction: kind 0 is a
// victim request (set_index, valid_mask), kind 1 an access update
// (set_index, way, address, pc, hit). A victim request yields one
// transaction on the output channel (out_valid/out_ready, victim_way);
// an update yields none.
// Sequence: accept, row read, execute; victim_way is registered in execute
// and held in the output state. An update returns to idle after execute.
// One transaction is in flight at a time; the per-set memory read and
// write-back of the RRPV row set the rate.
// After reset the block sweeps the per-set memories with in_ready low;
// the register port works during the sweep.
// While out_ready is low the result is held and no input is taken.
// Register 0 at address 0: stream_delta_limit (16 bits, reset 128).
module ship_drrip_stream_bypass_replacement #(
    parameter int unsigned SETS         = 2048,
    parameter int unsigned WAYS         = 16,
    parameter int unsigned SIG_BITS     = 5,
    parameter int unsigned PSEL_WIDTH   = 10,
    parameter int unsigned LEADER_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [10:0] set_index,
    input  logic [3:0]  way,
    input  logic [15:0] valid_mask,
    input  logic [47:0] address,
    input  logic [47:0] pc,
    input  logic        hit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  victim_way
);
    import sdsbr_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_INIT;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? 32'(limit_reg) : 32'd0;

    sdsbr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    sdsbr_dp #(
        .SETS(SETS), .WAYS(WAYS), .SIG_BITS(SIG_BITS),
        .PSEL_WIDTH(PSEL_WIDTH), .LEADER_COUNT(LEADER_COUNT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .limit(limit_reg),
        .kind(kind), .set_index(set_index), .way(way), .valid_mask(valid_mask),
        .address(address), .pc(pc), .hit(hit), .victim_way(victim_way)
    );

    assign out_valid = cmd.out_valid;
endmodule

// File: sv/sdsbr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the replacement engine, bound to the top level.
// No dependencies.
module sdsbr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] victim_way
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(victim_way))
        else $error("result dropped");
    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind |=> ##2 !out_valid)
        else $error("update produced result");
    a_victim_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !kind |=> ##2 out_valid)
        else $error("victim result missing");
endmodule

bind ship_drrip_stream_bypass_replacement sdsbr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .out_valid(out_valid), .out_ready(out_ready),
    .victim_way(victim_way)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ship_drrip_stream_bypass_replacement.
// Drives victim requests and access updates, predicts victim ways with an
// internal replacement model; depends on sdsbr_pkg and the RTL.
module tb;
    import sdsbr_pkg::*;

    localparam int NSETS = 2048;
    localparam int NWAYS = 16;
    localparam int LEADERS = 64;
    localparam logic [9:0] SEL_TOP = 10'h3FF;
    localparam logic [9:0] SEL_MID = 10'd511;
    localparam logic [0:0] REG_STREAM_LIMIT = 1'b0;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [10:0] set_index = '0;
    logic [3:0] way = '0;
    logic [15:0] valid_mask = '0;
    logic [47:0] address = '0;
    logic [47:0] pc = '0;
    logic hit = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] victim_way;

    ship_drrip_stream_bypass_replacement dut (.*);

    always #5 clk = ~clk;

    logic [1:0] rrpv [NSETS][NWAYS];
    logic [1:0] reuse [32];
    logic [1:0] stride_lvl [NSETS];
    logic [47:0] prev_addr [NSETS];
    logic [9:0] duel_sel;
    logic [4:0] access_cnt;
    logic [15:0] stream_limit;
    logic [3:0] victim_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int errors = 0;
    int quiet = 0;

    task automatic model_reset();
        foreach (rrpv[s, w]) rrpv[s][w] = RRPV_INIT;
        foreach (reuse[i]) reuse[i] = REUSE_INIT;
        foreach (stride_lvl[i]) stride_lvl[i] = '0;
        foreach (prev_addr[i]) prev_addr[i] = '0;
        duel_sel = SEL_MID;
        access_cnt = '0;
        stream_limit = LIMIT_INIT;
    endtask

    function automatic logic [3:0] choose_victim(int s, logic [15:0] vm);
        logic [1:0] top;
        top = 0;
        for (int w = 0; w < NWAYS; w++)
            if (!vm[w]) return w[3:0];
        for (int w = 0; w < NWAYS; w++)
            if (rrpv[s][w] > top) top = rrpv[s][w];
        for (int w = 0; w < NWAYS; w++)
            rrpv[s][w] = rrpv[s][w] + (RRPV_MAX - top);
        for (int w = 0; w < NWAYS; w++)
            if (rrpv[s][w] == RRPV_MAX) return w[3:0];
        return 4'd0;
    endfunction

    task automatic apply_access(int s, logic [3:0] w, logic [47:0] a, logic [47:0] p,
                                logic h);
        logic [4:0] sig;
        logic [47:0] delta;
        logic streaming, leader, brrip;
        logic [1:0] ins;
        int stride, idx;
        access_cnt = access_cnt + 5'd1;
        sig = p[4:0] ^ p[9:5] ^ p[14:10];
        if (h) begin
            if (reuse[sig] < 3) reuse[sig]++;
        end
        else if (reuse[sig] > 0) reuse[sig]--;
        delta = 0;
        if (prev_addr[s] != 0)
            delta = (a >= prev_addr[s]) ? a - prev_addr[s] : prev_addr[s] - a;
        prev_addr[s] = a;
        if (delta != 0 && delta <= {32'd0, stream_limit}) begin
            if (stride_lvl[s] < 3) stride_lvl[s]++;
        end
        else if (stride_lvl[s] > 0) stride_lvl[s]--;
        streaming = stride_lvl[s] >= 2;
        stride = NSETS / LEADERS;
        idx = s / stride;
        leader = (s % stride == 0) && idx < LEADERS;
        brrip = leader ? (idx >= LEADERS / 2) : (duel_sel >= SEL_MID);
        if (streaming || reuse[sig] == 0) ins = RRPV_MAX;
        else if (brrip && access_cnt == 0) ins = 2'd0;
        else ins = 2'd2;
        if (h) ins = 2'd0;
        rrpv[s][w] = ins;
        if (leader && !h) begin
            if (idx < LEADERS / 2) begin
                if (duel_sel < SEL_TOP) duel_sel++;
            end
            else if (duel_sel > 0) duel_sel--;
        end
    endtask

    task automatic send_item(logic k, logic [10:0] s, logic [3:0] w, logic [15:0] vm,
                             logic [47:0] a, logic [47:0] p, logic h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        set_index <= s;
        way <= w;
        valid_mask <= vm;
        address <= a;
        pc <= p;
        hit <= h;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (k == KIND_VICTIM) victim_q.push_back(choose_victim(s, vm));
        else apply_access(s, w, a, p, h);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_STREAM_LIMIT;
        pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        stream_limit = v;
    endtask

    task automatic send_victim(logic [10:0] s, logic [15:0] vm);
        send_item(KIND_VICTIM, s, 4'($urandom), vm, 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 1'($urandom));
    endtask

    task automatic send_access(logic [10:0] s, logic [3:0] w, logic [47:0] a,
                               logic [47:0] p, logic h);
        send_item(KIND_UPDATE, s, w, 16'($urandom), a, p, h);
    endtask

    task automatic test_directed();
        send_victim(11'd0, 16'hFFFF);
        send_victim(11'd0, 16'h7FFF);
        send_victim(11'd2047, 16'h0000);
        send_access(11'd0, 4'd15, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_access(11'd0, 4'd0, 48'hFFFF_FFFF_FF80, 48'h0, 1'b0);
        send_access(11'd0, 4'd1, 48'hFFFF_FFFF_FF00, 48'h0, 1'b0);
        send_access(11'd0, 4'd2, 48'hFFFF_FFFF_FE80, 48'h0, 1'b0);
        send_victim(11'd0, 16'hFFFF);
        send_access(11'd32, 4'd3, 48'h1000, 48'h21, 1'b0);
        send_access(11'd1024, 4'd4, 48'h2000, 48'h42, 1'b0);
        send_access(11'd2047, 4'd5, 48'h3000, 48'h0, 1'b1);
        send_access(11'd5, 4'd6, 48'h0, 48'h5, 1'b0);
        send_victim(11'd2047, 16'hFFFF);
        send_victim(11'd5, 16'hBFFF);
        send_victim(11'd32, 16'hFFFF);
        wait_drained();
    endtask

    task automatic random_phase(int n);
        logic [10:0] s;
        logic [47:0] base;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: send_victim(11'($urandom), 16'($urandom));
                1, 2: send_victim(11'($urandom_range(7) * 32), 16'hFFFF);
                3: send_access(11'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
                               48'({$urandom, $urandom}), 1'($urandom));
                default: begin
                    s = 11'($urandom_range(7) * 32 + $urandom_range(1));
                    base = 48'({$urandom, $urandom});
                    for (int j = 0; j < 4; j++)
                        send_access(s, 4'($urandom),
                                    base + 48'(j * $urandom_range(300)),
                                    48'($urandom_range(63)) << ($urandom_range(3) * 12),
                                    $urandom_range(3) == 0);
                    i += 3;
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_idle_pct = 0;
        random_phase(20);
        wait_drained();
    endtask

    initial begin
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 22;
        recv_idle_pct = 76;
        write_limit(16'd1);
        random_phase(450);
        wait_drained();
        send_idle_pct = 76;
        recv_idle_pct = 22;
        write_limit(16'hFFFF);
        random_phase(450);
        wait_drained();
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(16'd0);
        random_phase(400);
        wait_drained();
        write_limit(16'd200);
        random_phase(400);
        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (victim_q.size() == 0) begin
                $error("victim_way: unexpected transaction, actual %0d", victim_way);
                errors++;
            end
            else begin
                if (victim_way !== victim_q[0]) begin
                    $error("victim_way: expected %0d actual %0d", victim_q[0], victim_way);
                    errors++;
                end
                void'(victim_q.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule
